// ----- src/latin_hypercube_sampler_top_macros.svh -----
// ----------------------------------------------------------------------------
// Latin hypercube sampler assertion macros
// Shared property shorthands for the sampler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LATIN_HYPERCUBE_SAMPLER_TOP_MACROS_SVH
`define LATIN_HYPERCUBE_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LHS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define LHS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Latin hypercube sampler package
// Shared constants, codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package lhs_pkg;

  // Default sizing
  localparam int MAX_VARS_DEF   = 16;
  localparam int MAX_DOMAIN_DEF = 256;

  // Fixed field widths
  localparam int RAND_W      = 16;
  localparam int VALUE_W     = 8;
  localparam int SLOT_OUT_W  = 4;
  localparam int SAMPLE_W    = 8;
  localparam int NUM_VARS_W  = 5;
  localparam int DOMAIN_W    = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int OUT_DATA_W  = 24;
  localparam int STEP_W      = $clog2(RAND_W);

  // Register reset values
  localparam logic [NUM_VARS_W-1:0] NUM_VARS_RESET    = 5'd1;
  localparam logic [DOMAIN_W-1:0]   DOMAIN_SIZE_RESET = 9'd256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SIZE = 1'b1;

  // Operation codes
  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_CNT,
    ST_CHK,
    ST_DIV,
    ST_VRD,
    ST_VLAT,
    ST_SRD,
    ST_SWR,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start_fill;
    logic fill_step;
    logic start_draw;
    logic chk;
    logic div_step;
    logic val_latch;
    logic rd_next;
    logic shift_wr;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_done;
    logic exhausted;
    logic div_done;
    logic shift_done;
    logic out_free;
  } status_t;

endpackage

// ----- src/latin_hypercube_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Latin hypercube sampler
// Draws pool entries without replacement, one pool per variable.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction carries
//  s_axis    in         tuser: op (0 draw, 1 restart); tdata: rand_value
//  m_axis    out        tdata: value, var_slot, sample_number; tlast: end_of_sample;
//                       tuser: status
//  cfg       in         cfg_index: register; cfg_data: value written
//
//  A draw runs from acceptance until s_axis_tready returns: a bit-serial
//  remainder over the 16 bits of rand_value, then a read and a write for each
//  pool entry above the picked one, shifted down through the pool memory.
//  An exhausted draw skips the remainder and the shift.
//  A restart, and reset, sweep the whole pool memory (MAX_VARS * MAX_DOMAIN
//  entries, each rounded up to a power of two, 4096 by default) with s_axis_tready low.
//  A waiting result does not block the next transaction until that draw finishes.
// ----------------------------------------------------------------------------
`include "latin_hypercube_sampler_top_macros.svh"

module latin_hypercube_sampler_top
  import lhs_pkg::*;
#(
  parameter int MAX_VARS   = MAX_VARS_DEF,
  parameter int MAX_DOMAIN = MAX_DOMAIN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [RAND_W-1:0]     s_axis_tdata,   // [15:0] rand_value
  input  logic                  s_axis_tuser,   // [0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] value, [11:8] var_slot,
                                                // [19:12] sample_number, [23:20] zero
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser,   // [0] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NV_W  = $clog2(MAX_VARS + 1);
  localparam int CNT_W = $clog2(MAX_DOMAIN + 1);

  logic [NUM_VARS_W-1:0] num_vars;
  logic [DOMAIN_W-1:0]   domain_size;
  logic [NV_W-1:0]       eff_vars;
  logic [CNT_W-1:0]      eff_domain;
  cmd_t                  cmd;
  status_t               status;
  logic [VALUE_W-1:0]    out_value;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [SAMPLE_W-1:0]   out_sample;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars    <= NUM_VARS_RESET;
      domain_size <= DOMAIN_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_VARS:    num_vars    <= cfg_data[NUM_VARS_W-1:0];
        CFG_DOMAIN_SIZE: domain_size <= cfg_data[DOMAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into the supported range
  always_comb begin
    if (num_vars == '0) begin
      eff_vars = NV_W'(1);
    end else if (int'(num_vars) > MAX_VARS) begin
      eff_vars = NV_W'(MAX_VARS);
    end else begin
      eff_vars = NV_W'(num_vars);
    end
    if (domain_size == '0) begin
      eff_domain = CNT_W'(1);
    end else if (int'(domain_size) > MAX_DOMAIN) begin
      eff_domain = CNT_W'(MAX_DOMAIN);
    end else begin
      eff_domain = CNT_W'(domain_size);
    end
  end

  lhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .op       (s_axis_tuser),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lhs_dp #(
    .MAX_VARS   (MAX_VARS),
    .MAX_DOMAIN (MAX_DOMAIN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rnd        (s_axis_tdata),
    .eff_vars   (eff_vars),
    .eff_domain (eff_domain),
    .out_ready  (m_axis_tready),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_value  (out_value),
    .out_slot   (out_slot),
    .out_sample (out_sample),
    .out_last   (m_axis_tlast),
    .out_exh    (m_axis_tuser)
  );

  // Pack result fields
  assign m_axis_tdata = {4'b0000, out_sample, out_slot, out_value};

  // Checks
  `LHS_ASSERT_NEXT(a_one_draw_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in progress")
  `LHS_ASSERT_SAME(a_exhausted_zero, clk, rst, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == '0) && !m_axis_tlast, "exhausted result carries nonzero fields")
  `LHS_ASSERT_SAME(a_result_from_finish, clk, rst, $rose(m_axis_tvalid), $past(cmd.finish), "result appeared without a finished draw")

endmodule

// ----- src/lhs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lhs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sampler controller
// Sequences refill sweeps and draws: count read, remainder, pick, compaction.
// ----------------------------------------------------------------------------
module lhs_ctrl
  import lhs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    op,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (status.fill_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (op == OP_RESTART) ? ST_FILL : ST_CNT;
      end
      ST_CNT:  state_next = ST_CHK;
      ST_CHK:  state_next = status.exhausted ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (status.div_done) state_next = ST_VRD;
      end
      ST_VRD:  state_next = ST_VLAT;
      ST_VLAT: state_next = ST_SRD;
      ST_SRD:  state_next = status.shift_done ? ST_FIN : ST_SWR;
      ST_SWR:  state_next = ST_SRD;
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_FILL;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_FILL: cmd.fill_step = 1'b1;
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.start_fill  = in_valid && (op == OP_RESTART);
        cmd.start_draw  = in_valid && (op == OP_DRAW);
      end
      ST_CNT:  ;
      ST_CHK:  cmd.chk = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_VRD:  ;
      ST_VLAT: cmd.val_latch = 1'b1;
      ST_SRD:  cmd.rd_next = 1'b1;
      ST_SWR:  cmd.shift_wr = 1'b1;
      ST_FIN:  cmd.finish = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/lhs_dp.sv -----
// ----------------------------------------------------------------------------
// Sampler datapath
// Pool and count memories, counters, bit-serial remainder, output register.
// ----------------------------------------------------------------------------
module lhs_dp
  import lhs_pkg::*;
#(
  parameter int MAX_VARS   = MAX_VARS_DEF,
  parameter int MAX_DOMAIN = MAX_DOMAIN_DEF,
  parameter int SLOT_W     = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
  parameter int IDX_W      = $clog2(MAX_DOMAIN),
  parameter int CNT_W      = $clog2(MAX_DOMAIN + 1),
  parameter int NV_W       = $clog2(MAX_VARS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [RAND_W-1:0]     rnd,
  input  logic [NV_W-1:0]       eff_vars,
  input  logic [CNT_W-1:0]      eff_domain,
  input  logic                  out_ready,
  output status_t               status,
  output logic                  out_valid,
  output logic [VALUE_W-1:0]    out_value,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic                  out_last,
  output logic                  out_exh
);

  localparam int AW       = SLOT_W + IDX_W;
  localparam int FILL_RST = (int'(DOMAIN_SIZE_RESET) > MAX_DOMAIN) ? MAX_DOMAIN
                                                                   : int'(DOMAIN_SIZE_RESET);

  logic [CNT_W-1:0]  fill_size;
  logic [CNT_W-1:0]  sample_counter;
  logic [SLOT_W-1:0] var_counter;
  logic [AW-1:0]     sweep;
  logic [RAND_W-1:0] rnd_sh;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  val;
  logic              exh;

  logic              pool_we;
  logic [AW-1:0]     pool_waddr;
  logic [IDX_W-1:0]  pool_wdata;
  logic [AW-1:0]     pool_raddr;
  logic [IDX_W-1:0]  pool_rdata;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              last;

  // Memory port selection
  always_comb begin
    pool_we    = cmd.fill_step || cmd.shift_wr;
    pool_waddr = cmd.fill_step ? sweep : {var_counter, pos};
    pool_wdata = cmd.fill_step ? sweep[IDX_W-1:0] : pool_rdata;
    pool_raddr = cmd.rd_next ? {var_counter, IDX_W'(pos + IDX_W'(1))}
                             : {var_counter, rem[IDX_W-1:0]};
    cnt_we     = (cmd.fill_step && (sweep[IDX_W-1:0] == '0)) || (cmd.finish && !exh);
    cnt_waddr  = cmd.fill_step ? sweep[AW-1:IDX_W] : var_counter;
    cnt_wdata  = cmd.fill_step ? fill_size : CNT_W'(cnt - CNT_W'(1));
  end

  lhs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (1 << AW)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  lhs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << SLOT_W)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (var_counter),
    .rdata (cnt_rdata)
  );

  // One restoring step of the remainder
  always_comb begin
    trial     = {rem, rnd_sh[RAND_W-1]};
    trial_sub = trial - {1'b0, cnt};
  end

  assign last = (NV_W'(var_counter) + NV_W'(1)) >= eff_vars;

  // Status toward the controller
  always_comb begin
    status.fill_done  = (sweep == '1);
    status.exhausted  = (sample_counter >= fill_size) || (cnt_rdata == '0);
    status.div_done   = (step == STEP_W'(RAND_W - 1));
    status.shift_done = (CNT_W'(pos) + CNT_W'(1)) >= cnt;
    status.out_free   = !out_valid || out_ready;
  end

  // Refill sweep and run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep          <= '0;
      fill_size      <= CNT_W'(FILL_RST);
      sample_counter <= '0;
      var_counter    <= '0;
    end else begin
      if (cmd.start_fill) begin
        sweep          <= '0;
        fill_size      <= eff_domain;
        sample_counter <= '0;
        var_counter    <= '0;
      end else if (cmd.fill_step) begin
        sweep <= AW'(sweep + AW'(1));
      end
      if (cmd.finish && !exh) begin
        if (last) begin
          var_counter    <= '0;
          sample_counter <= CNT_W'(sample_counter + CNT_W'(1));
        end else begin
          var_counter <= SLOT_W'(var_counter + SLOT_W'(1));
        end
      end
    end
  end

  // Draw working registers
  always_ff @(posedge clk) begin
    if (cmd.start_draw) begin
      rnd_sh <= rnd;
    end
    if (cmd.chk) begin
      cnt  <= cnt_rdata;
      rem  <= '0;
      step <= '0;
      exh  <= status.exhausted;
    end
    if (cmd.div_step) begin
      rnd_sh <= {rnd_sh[RAND_W-2:0], 1'b0};
      step   <= STEP_W'(step + STEP_W'(1));
      if (trial >= {1'b0, cnt}) begin
        rem <= CNT_W'(trial_sub);
      end else begin
        rem <= CNT_W'(trial);
      end
    end
    if (cmd.val_latch) begin
      val <= pool_rdata;
      pos <= rem[IDX_W-1:0];
    end
    if (cmd.shift_wr) begin
      pos <= IDX_W'(pos + IDX_W'(1));
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_exh    <= exh;
      out_value  <= exh ? '0 : VALUE_W'(val);
      out_slot   <= exh ? '0 : SLOT_OUT_W'(var_counter);
      out_sample <= exh ? '0 : SAMPLE_W'(sample_counter);
      out_last   <= !exh && last;
    end
  end

endmodule
